FILE: design/sul_pkg.sv
// Shared types and constants for the SPI unlock and readout block.
package sul_pkg;

  // Default length of the code entry buffer, in characters.
  localparam int CODE_CHARS_DEF = 12;

  // Register map: one register, indexed by the word address.
  localparam logic REG_UNLOCK_CODE = 1'b0;
  localparam logic [15:0] UNLOCK_CODE_RST = 16'd12;

  // Special received bytes while locked.
  localparam logic [7:0] RX_COMPARE = 8'd0;
  localparam logic [7:0] RX_RESTART = 8'd1;

  // Readout commands while unlocked.
  localparam logic [7:0] CMD_PWM0    = 8'd10;
  localparam logic [7:0] CMD_PWM1    = 8'd20;
  localparam logic [7:0] CMD_PWM2    = 8'd30;
  localparam logic [7:0] CMD_COND1   = 8'd41;
  localparam logic [7:0] CMD_COND2   = 8'd42;
  localparam logic [7:0] CMD_COND3   = 8'd43;
  localparam logic [7:0] CMD_ADC_LO  = 8'd176;
  localparam logic [7:0] CMD_ADC_HI  = 8'd177;

  // Reply codes.
  localparam logic [7:0] REPLY_FAIL = 8'd1;
  localparam logic [7:0] REPLY_OK   = 8'd2;
  localparam logic [7:0] REPLY_HOT  = 8'd28;

  // Parse phases.
  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // Magnitude saturation point; it can never equal a 16-bit code.
  localparam logic [16:0] VALUE_CAP = 17'd65536;

  // Parser state carried from one character to the next.
  typedef struct packed {
    logic [1:0]  phase;
    logic        neg;
    logic [16:0] value;
  } entry_t;

endpackage

FILE: design/spi_slave_unlock_and_readout_top.sv
// Top level of the SPI unlock and readout block: registers, control and readout.
// A byte taken into the input register has its reply, if it makes one, written to the
// output register once that register is free; the output register drives out_valid.
// Throughput: one byte per cycle while replies can leave; a byte that makes a reply waits
// in the input register while the output register is full. The input register feeds
// the state update and reply select, and the output register decouples the result side.
// Reset (synchronous, rst_n low): locked, entry cleared, unlock code back to 12, both
// pipeline registers empty. No clearing pass is needed.
module spi_slave_unlock_and_readout_top #(
  parameter int CODE_CHARS = sul_pkg::CODE_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic [9:0]  in_adc_value,
  input  logic [7:0]  in_pwm0_compare,
  input  logic [15:0] in_pwm1_compare,
  input  logic [7:0]  in_pwm2_compare,
  input  logic [2:0]  in_cond_flags,
  input  logic        in_overheat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_reply_byte,
  output logic        out_lock_open,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sul_pkg::*;

  localparam int CntW = $clog2(CODE_CHARS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(CODE_CHARS);

  // Configuration register.
  logic [15:0] unlock_code_r;
  logic        cfg_write;

  // Input register.
  logic        s1_valid_r;
  logic [7:0]  rx_r;
  logic [9:0]  adc_r;
  logic [7:0]  pwm0_r;
  logic [7:0]  pwm1_r;
  logic [7:0]  pwm2_r;
  logic [2:0]  cond_r;
  logic        hot_r;

  // Lock and entry state.
  logic            locked_r;
  logic            locked_nxt;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;
  logic            ovf_r;
  logic            ovf_nxt;
  entry_t          entry_r;
  entry_t          entry_nxt;
  entry_t          entry_parsed;

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_reply_r;
  logic       out_lock_r;

  logic       has_result;
  logic [7:0] reply;
  logic       reply_lock;
  logic       match;
  logic       out_free;
  logic       advance;
  logic       in_xfer;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_UNLOCK_CODE);
  assign cfg_prdata = (cfg_paddr[2] == REG_UNLOCK_CODE) ? {16'd0, unlock_code_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unlock_code_r <= UNLOCK_CODE_RST;
    end else if (cfg_write) begin
      unlock_code_r <= cfg_pwdata[15:0];
    end
  end

  // Flow control: the item in the input register moves on when it makes no reply
  // or the output register can take the reply.
  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && (!has_result || out_free);
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rx_r   <= in_rx_byte;
      adc_r  <= in_adc_value;
      pwm0_r <= in_pwm0_compare;
      pwm1_r <= in_pwm1_compare[7:0];
      pwm2_r <= in_pwm2_compare;
      cond_r <= in_cond_flags;
      hot_r  <= in_overheat;
    end
  end

  sul_parse u_parse (
    .ch      (rx_r),
    .entry_i (entry_r),
    .entry_o (entry_parsed)
  );

  assign match = !ovf_r && (entry_r.value == {1'b0, unlock_code_r}) &&
                 (!entry_r.neg || (entry_r.value == 17'd0));

  always_comb begin
    locked_nxt = locked_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    entry_nxt  = entry_r;
    has_result = 1'b0;
    reply      = REPLY_FAIL;
    reply_lock = 1'b0;
    if (locked_r) begin
      if (rx_r == RX_RESTART) begin
        cnt_nxt   = '0;
        ovf_nxt   = 1'b0;
        entry_nxt = '{phase: PH_SKIP, neg: 1'b0, value: 17'd0};
      end else if (rx_r != RX_COMPARE) begin
        if (cnt_r >= CntMax) begin
          ovf_nxt = 1'b1;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          entry_nxt = entry_parsed;
        end
      end else begin
        has_result = 1'b1;
        if (match) begin
          locked_nxt = 1'b0;
          reply      = REPLY_OK;
          reply_lock = 1'b1;
        end
      end
    end else begin
      has_result = 1'b1;
      reply_lock = 1'b1;
      case (rx_r)
        CMD_ADC_LO: reply = adc_r[7:0];
        CMD_ADC_HI: reply = {6'd0, adc_r[9:8]};
        CMD_PWM0:   reply = hot_r ? REPLY_HOT : pwm0_r;
        CMD_PWM1:   reply = hot_r ? REPLY_HOT : pwm1_r;
        CMD_PWM2:   reply = hot_r ? REPLY_HOT : pwm2_r;
        CMD_COND1:  reply = hot_r ? REPLY_HOT : {7'd0, cond_r[0]};
        CMD_COND2:  reply = hot_r ? REPLY_HOT : {7'd0, cond_r[1]};
        CMD_COND3:  reply = hot_r ? REPLY_HOT : {7'd0, cond_r[2]};
        default:    has_result = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r <= 1'b1;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      entry_r  <= '{phase: PH_SKIP, neg: 1'b0, value: 17'd0};
    end else if (advance) begin
      locked_r <= locked_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      entry_r  <= entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && has_result) begin
      out_reply_r <= reply;
      out_lock_r  <= reply_lock;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reply_byte = out_reply_r;
  assign out_lock_open  = out_lock_r;

`ifndef NO_ASSERTIONS
  // Once opened, the lock stays open until reset.
  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !locked_r |=> !locked_r)
    else $error("lock closed again without reset");

  // The entry count saturates at the buffer length.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntMax)
    else $error("entry count beyond buffer length");

  // Overflow is only possible with a full buffer.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == CntMax))
    else $error("overflow flagged with buffer not full");

  // A reply with the lock closed is always the failure code.
  a_fail_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_lock_r) |-> (out_reply_r == REPLY_FAIL))
    else $error("closed-lock reply is not the failure code");

  // While unlocked, no entry state changes.
  a_entry_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (!locked_r && $past(!locked_r) && $past(rst_n)) |-> $stable(cnt_r) && $stable(ovf_r))
    else $error("entry state changed while unlocked");
`endif

endmodule

FILE: design/sul_parse.sv
// One-character step of the decimal code entry parser.
module sul_parse (
  input  logic [7:0]      ch,
  input  sul_pkg::entry_t entry_i,
  output sul_pkg::entry_t entry_o
);
  import sul_pkg::*;

  logic        digit;
  logic        blank;
  logic [3:0]  dval;
  logic [19:0] ext;
  logic [19:0] acc;
  logic [16:0] value_add;

  assign digit = (ch >= 8'd48) && (ch <= 8'd57);
  assign blank = (ch == 8'd32) || ((ch >= 8'd9) && (ch <= 8'd13));
  assign dval  = ch[3:0];

  // value * 10 + digit, built from two shifts.
  assign ext = {3'b000, entry_i.value};
  assign acc = (ext << 3) + (ext << 1) + {16'd0, dval};
  assign value_add = (acc > {3'b000, VALUE_CAP}) ? VALUE_CAP : acc[16:0];

  always_comb begin
    entry_o = entry_i;
    case (entry_i.phase)
      PH_SKIP: begin
        if (blank) begin
          entry_o = entry_i;
        end else if ((ch == 8'd43) || (ch == 8'd45)) begin
          entry_o.neg   = (ch == 8'd45);
          entry_o.phase = PH_DIGITS;
        end else if (digit) begin
          entry_o.phase = PH_DIGITS;
          entry_o.value = value_add;
        end else begin
          entry_o.phase = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          entry_o.value = value_add;
        end else begin
          entry_o.phase = PH_DONE;
        end
      end
      default: begin
        entry_o = entry_i;
      end
    endcase
  end

endmodule

FILE: tb/sv/tb_spi_slave_unlock_and_readout_top.sv
// Self-checking testbench for the SPI unlock and readout block.
module tb_spi_slave_unlock_and_readout_top;
  import sul_pkg::*;

  localparam int ENTRY_MAX   = CODE_CHARS_DEF;
  localparam int WATCHDOG    = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE      = 4;
  localparam int LOCKED_ROWS = 16;
  localparam int PLAN_ROWS   = 25;
  localparam int PER_CODE    = 110;
  localparam int OPEN_ITEMS  = 450;

  localparam logic [7:0] WS_LO    = 8'd9;
  localparam logic [7:0] WS_HI    = 8'd13;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_SLASH = "/";

  typedef struct packed {
    logic [7:0]  rx;
    logic [9:0]  adc;
    logic [7:0]  pwm0;
    logic [15:0] pwm1;
    logic [7:0]  pwm2;
    logic [2:0]  cond;
    logic        hot;
  } spi_xfer_t;

  typedef struct packed {
    logic [7:0] reply;
    logic       lock_open;
  } reply_t;

  typedef struct packed {
    spi_xfer_t xfer;
    logic      typed;
    reply_t    want;
  } plan_row_t;

  localparam reply_t NO_WANT = '{8'd0, 1'b0};

  localparam logic [7:0] READ_CMDS [8] = '{CMD_ADC_LO, CMD_ADC_HI, CMD_PWM0, CMD_PWM1,
                                           CMD_PWM2, CMD_COND1, CMD_COND2, CMD_COND3};

  // Rows before LOCKED_ROWS run right after reset with the default code of 12;
  // the rest run once the block has been unlocked.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{'{RX_COMPARE, 10'd0, 8'd0, 16'd0, 8'd0, 3'd0, 1'b0}, 1'b1, '{REPLY_FAIL, 1'b0}},
    '{'{CH_SPACE, 10'd1023, 8'd255, 16'hFFFF, 8'd255, 3'd7, 1'b1}, 1'b0, NO_WANT},
    '{'{WS_LO, 10'd0, 8'd0, 16'd0, 8'd0, 3'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{WS_HI, 10'd512, 8'd128, 16'h8000, 8'd128, 3'd4, 1'b1}, 1'b0, NO_WANT},
    '{'{CH_PLUS, 10'd0, 8'd0, 16'd0, 8'd0, 3'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{"1", 10'd0, 8'd0, 16'd0, 8'd0, 3'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{"3", 10'd0, 8'd0, 16'd0, 8'd0, 3'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{RX_COMPARE, 10'd1023, 8'd255, 16'hFFFF, 8'd255, 3'd7, 1'b1}, 1'b1,
      '{REPLY_FAIL, 1'b0}},
    '{'{RX_RESTART, 10'd0, 8'd0, 16'd0, 8'd0, 3'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{CH_MINUS, 10'd0, 8'd0, 16'd0, 8'd0, 3'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{"1", 10'd0, 8'd0, 16'd0, 8'd0, 3'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{"2", 10'd0, 8'd0, 16'd0, 8'd0, 3'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{RX_COMPARE, 10'd0, 8'd0, 16'd0, 8'd0, 3'd0, 1'b0}, 1'b1, '{REPLY_FAIL, 1'b0}},
    '{'{RX_RESTART, 10'd0, 8'd0, 16'd0, 8'd0, 3'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{8'd255, 10'd0, 8'd0, 16'd0, 8'd0, 3'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{RX_COMPARE, 10'd0, 8'd0, 16'd0, 8'd0, 3'd0, 1'b0}, 1'b1, '{REPLY_FAIL, 1'b0}},
    '{'{CMD_ADC_LO, 10'd1023, 8'd0, 16'd0, 8'd0, 3'd0, 1'b1}, 1'b1, '{8'd255, 1'b1}},
    '{'{CMD_ADC_HI, 10'd1023, 8'd0, 16'd0, 8'd0, 3'd0, 1'b0}, 1'b1, '{8'd3, 1'b1}},
    '{'{CMD_PWM0, 10'd0, 8'h5A, 16'd0, 8'd0, 3'd0, 1'b1}, 1'b1, '{REPLY_HOT, 1'b1}},
    '{'{CMD_PWM1, 10'd0, 8'd0, 16'hFF00, 8'd0, 3'd0, 1'b0}, 1'b1, '{8'd0, 1'b1}},
    '{'{CMD_PWM2, 10'd0, 8'd0, 16'd0, 8'd255, 3'd0, 1'b0}, 1'b1, '{8'd255, 1'b1}},
    '{'{CMD_COND1, 10'd0, 8'd0, 16'd0, 8'd0, 3'b001, 1'b0}, 1'b1, '{8'd1, 1'b1}},
    '{'{CMD_COND2, 10'd0, 8'd0, 16'd0, 8'd0, 3'b101, 1'b0}, 1'b1, '{8'd0, 1'b1}},
    '{'{CMD_COND3, 10'd0, 8'd0, 16'd0, 8'd0, 3'b100, 1'b1}, 1'b1, '{REPLY_HOT, 1'b1}},
    '{'{RX_COMPARE, 10'd1023, 8'd255, 16'hFFFF, 8'd255, 3'd7, 1'b0}, 1'b0, NO_WANT}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic [9:0]  in_adc_value;
  logic [7:0]  in_pwm0_compare;
  logic [15:0] in_pwm1_compare;
  logic [7:0]  in_pwm2_compare;
  logic [2:0]  in_cond_flags;
  logic        in_overheat;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_reply_byte;
  logic        out_lock_open;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow of the lock and the code entry, kept in step with accepted transfers.
  bit          gate_locked = 1'b1;
  logic [3:0]  entry_count = '0;
  logic [1:0]  entry_phase = PH_SKIP;
  logic        entry_neg = 1'b0;
  logic [16:0] entry_value = '0;
  logic        entry_over = 1'b0;
  logic [15:0] code_shadow = UNLOCK_CODE_RST;
  reply_t      pending_replies[$];

  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  spi_slave_unlock_and_readout_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic bit entry_unlocks();
    return !entry_over && entry_value == {1'b0, code_shadow} &&
           (!entry_neg || entry_value == '0);
  endfunction

  task automatic predict_transfer(input spi_xfer_t x, output bit made);
    reply_t      r;
    logic [31:0] grown;
    bit          digit;
    bit          blank;
    bit          take;
    digit = x.rx >= CH_ZERO && x.rx <= CH_NINE;
    blank = x.rx == CH_SPACE || (x.rx >= WS_LO && x.rx <= WS_HI);
    take = 1'b0;
    made = 1'b0;
    r = '{8'd0, 1'b1};
    if (gate_locked) begin
      if (x.rx == RX_RESTART) begin
        entry_count = '0;
        entry_phase = PH_SKIP;
        entry_neg = 1'b0;
        entry_value = '0;
        entry_over = 1'b0;
      end else if (x.rx == RX_COMPARE) begin
        made = 1'b1;
        if (entry_unlocks()) begin
          gate_locked = 1'b0;
          r.reply = REPLY_OK;
        end else begin
          r = '{REPLY_FAIL, 1'b0};
        end
      end else if (entry_count >= ENTRY_MAX) begin
        entry_over = 1'b1;
      end else begin
        entry_count++;
        case (entry_phase)
          PH_SKIP: begin
            if (x.rx == CH_PLUS || x.rx == CH_MINUS) begin
              entry_neg = x.rx == CH_MINUS;
              entry_phase = PH_DIGITS;
            end else if (digit) begin
              entry_phase = PH_DIGITS;
              take = 1'b1;
            end else if (!blank) begin
              entry_phase = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (digit) take = 1'b1;
            else entry_phase = PH_DONE;
          end
          default: ;
        endcase
        if (take) begin
          // The magnitude saturates so that a long digit run can never match.
          grown = entry_value * 32'd10 + (x.rx - CH_ZERO);
          entry_value = grown > VALUE_CAP ? VALUE_CAP : grown[16:0];
        end
      end
    end else begin
      made = 1'b1;
      case (x.rx)
        CMD_ADC_LO: r.reply = x.adc[7:0];
        CMD_ADC_HI: r.reply = {6'd0, x.adc[9:8]};
        CMD_PWM0:   r.reply = x.hot ? REPLY_HOT : x.pwm0;
        CMD_PWM1:   r.reply = x.hot ? REPLY_HOT : x.pwm1[7:0];
        CMD_PWM2:   r.reply = x.hot ? REPLY_HOT : x.pwm2;
        CMD_COND1:  r.reply = x.hot ? REPLY_HOT : {7'd0, x.cond[0]};
        CMD_COND2:  r.reply = x.hot ? REPLY_HOT : {7'd0, x.cond[1]};
        CMD_COND3:  r.reply = x.hot ? REPLY_HOT : {7'd0, x.cond[2]};
        default:    made = 1'b0;
      endcase
    end
    if (made) pending_replies.push_back(r);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_item(input spi_xfer_t x, input bit typed, input reply_t want);
    bit made;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid = 1'b1;
    in_rx_byte = x.rx;
    in_adc_value = x.adc;
    in_pwm0_compare = x.pwm0;
    in_pwm1_compare = x.pwm1;
    in_pwm2_compare = x.pwm2;
    in_cond_flags = x.cond;
    in_overheat = x.hot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_transfer(x, made);
    if (typed) begin
      if (made) pending_replies[pending_replies.size() - 1] = want;
      else pending_replies.push_back(want);
    end
    items_sent++;
    @(negedge clk);
  endtask

  function automatic spi_xfer_t random_status(input logic [7:0] rx);
    spi_xfer_t x;
    x.rx = rx;
    if ($urandom_range(0, 7) == 0) x.adc = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
    else x.adc = 10'($urandom);
    x.pwm0 = 8'($urandom);
    x.pwm1 = 16'($urandom);
    x.pwm2 = 8'($urandom);
    x.cond = 3'($urandom);
    x.hot = $urandom_range(0, 3) == 0;
    return x;
  endfunction

  task automatic send_byte(input logic [7:0] rx);
    push_item(random_status(rx), 1'b0, NO_WANT);
  endtask

  // One code entry while locked. Unless a match is wanted, a compare that would
  // unlock is turned into a restart so the lock stays closed for later settings.
  task automatic send_entry(input bit want_match);
    logic [7:0]  txt[$];
    logic [7:0]  num[$];
    logic [7:0]  ch;
    int unsigned target;
    int unsigned n;
    if (want_match || $urandom_range(0, 4) != 0) txt.push_back(RX_RESTART);
    if (!want_match && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 16)) txt.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 2)) begin
        n = $urandom_range(0, 5);
        txt.push_back(n == 5 ? CH_SPACE : WS_LO + 8'(n));
      end
      n = $urandom_range(0, 3);
      if (n == 1) txt.push_back(CH_PLUS);
      else if (n == 2 && (!want_match || code_shadow == '0)) txt.push_back(CH_MINUS);
      if (want_match) begin
        target = code_shadow;
      end else begin
        case ($urandom_range(0, 4))
          0: target = code_shadow;
          1: target = code_shadow + 1;
          2: target = code_shadow ^ (1 << $urandom_range(0, 15));
          3: target = $urandom_range(0, 65535);
          default: target = $urandom_range(65536, 999999999);
        endcase
      end
      do begin
        num.push_front(CH_ZERO + 8'(target % 10));
        target /= 10;
      end while (target != 0);
      repeat ($urandom_range(0, 2)) num.push_front(CH_ZERO);
      foreach (num[i]) txt.push_back(num[i]);
      if ($urandom_range(0, 2) == 0) begin
        ch = 8'($urandom_range(2, 255));
        txt.push_back(ch >= CH_ZERO && ch <= CH_NINE ? CH_SLASH : ch);
        if (!want_match) repeat ($urandom_range(0, 3)) txt.push_back(8'($urandom_range(2, 255)));
      end
      // Padding around the buffer length, so some entries overflow and some fill it.
      if (!want_match && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(2, ENTRY_MAX)) txt.push_back(8'($urandom_range(2, 255)));
    end
    txt.push_back(RX_COMPARE);
    foreach (txt[i]) begin
      if (txt[i] == RX_COMPARE && !want_match && entry_unlocks()) send_byte(RX_RESTART);
      else send_byte(txt[i]);
    end
  endtask

  // Holds the input side until every expected reply has come back.
  task automatic settle_for_config();
    in_valid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_code(input logic [15:0] code);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {REG_UNLOCK_CODE, 2'b00};
    cfg_pwdata = {16'd0, code};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    code_shadow = code;
    @(negedge clk);
    cfg_pwrite = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {16'd0, code_shadow})
      report_mismatch($sformatf("unlock code reads %0h, wrote %0h", cfg_prdata, code_shadow));
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  always @(posedge clk) begin : check_replies
    reply_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected reply %0d lock_open %0b",
                                  out_reply_byte, out_lock_open));
      end else begin
        exp_r = pending_replies.pop_front();
        if (out_reply_byte !== exp_r.reply)
          report_mismatch($sformatf("reply_byte %0d, expected %0d",
                                    out_reply_byte, exp_r.reply));
        if (out_lock_open !== exp_r.lock_open)
          report_mismatch($sformatf("lock_open %0b, expected %0b",
                                    out_lock_open, exp_r.lock_open));
      end
    end
  end

  initial begin : result_sink
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (mode)
        0: out_ready = 1'b1;
        1: out_ready = $urandom_range(0, 3) != 0;
        default: out_ready = $urandom_range(0, 2) == 0;
      endcase
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL spi_slave_unlock_and_readout_top");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] codes[4];
    int          mark;
    int          pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    in_adc_value = '0;
    in_pwm0_compare = '0;
    in_pwm1_compare = '0;
    in_pwm2_compare = '0;
    in_cond_flags = '0;
    in_overheat = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < LOCKED_ROWS; i++) push_item(PLAN[i].xfer, PLAN[i].typed, PLAN[i].want);

    // Locked entries against several codes, extremes first.
    codes[0] = 16'hFFFF;
    codes[1] = 16'h0000;
    codes[2] = 16'($urandom);
    codes[3] = 16'($urandom_range(1, 99));
    foreach (codes[k]) begin
      settle_for_config();
      write_code(codes[k]);
      mark = items_sent;
      while (items_sent < mark + PER_CODE) send_entry(1'b0);
    end

    settle_for_config();
    case ($urandom_range(0, 2))
      0: write_code(16'h0000);
      1: write_code(16'hFFFF);
      default: write_code(16'($urandom));
    endcase
    while (gate_locked) send_entry(1'b1);

    for (int i = LOCKED_ROWS; i < PLAN_ROWS; i++)
      push_item(PLAN[i].xfer, PLAN[i].typed, PLAN[i].want);

    for (int i = 0; i < OPEN_ITEMS; i++) begin
      // A long receiver hold fills the block while transfers keep coming.
      if (i == OPEN_ITEMS / 3) hold_req = 1'b1;
      if (i == 2 * OPEN_ITEMS / 3) begin
        settle_for_config();
        write_code(16'($urandom));
      end
      pick = $urandom_range(0, 9);
      send_byte(pick < 8 ? READ_CMDS[pick] : 8'($urandom));
    end

    in_valid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("PASS spi_slave_unlock_and_readout_top");
    else $display("FAIL spi_slave_unlock_and_readout_top");
    $finish;
  end

endmodule
